[rtl/wrdt_pkg.sv]
// Shared types and constants for the weighted random draw table.
// Holds the operation and status codes used by the top level and its checker.
// No dependencies.
package wrdt_pkg;

    // Operation carried by one item.
    typedef enum logic [1:0]
    {
        KIND_SET    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_DRAW   = 2'd3
    } kind_t;

    // Result status reported with every result.
    typedef enum logic [1:0]
    {
        STATUS_OK         = 2'd0,
        STATUS_UNKNOWN_ID = 2'd1,
        STATUS_EMPTY      = 2'd2,
        STATUS_ZERO_TOTAL = 2'd3
    } status_t;

    // Fixed port widths.
    localparam int ID_BITS          = 8;
    localparam int PROB_BITS        = 17;
    localparam int TOTAL_OUT_BITS   = 24;
    localparam int IN_WEIGHT_BITS   = 16;
    localparam int IN_FRACTION_BITS = 16;

endpackage

[rtl/wrdt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the weight table. No dependencies.
module wrdt_ram
#(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
)
(
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/weighted_random_draw_table.sv]
// Weighted random draw table: top level with the sequencer and the shared adder.
// Depends on wrdt_pkg and wrdt_ram.
//
// Usage
// The block keeps one weight per item id with a valid mark, the sum of all valid
// weights and a count of valid entries. An item is accepted at a rising edge where
// start is high and busy is low; kind selects set weight, remove, probability query
// or draw. Each accepted item yields exactly one result, shown for one cycle with
// done high: chosen_id, probability, weight_total and status. The receiver cannot
// stall, so a result is simply presented once and the block returns to idle.
//
// Steps from the accepting edge: a remove, a rejected item and a query on a zero
// total end in S_DECIDE; a set goes from S_DECIDE on to S_ADD_NEW. Any other query
// runs a restoring division in S_DIV (one restoring divide step per cycle). A draw
// runs a shift-add multiply of the total by the random fraction in S_MUL, one bit per
// cycle, and then a walk of the weight RAM in S_WALK at one entry per cycle, ending
// at the first match. Total, divide, multiply and walk arithmetic goes through one
// shared adder/subtractor; the single RAM read port sets the walk speed. busy is high
// for the whole operation, and a new item can be accepted in the done cycle.
//
// Reset: after rst_n rises the block sweeps the weight RAM, clearing one entry per
// cycle, for ITEMS cycles with busy high. The total and the count reset to zero.
module weighted_random_draw_table
    import wrdt_pkg::*;
#(
    parameter int ITEMS         = 256,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic [ID_BITS-1:0]          item_id,
    input  logic [IN_WEIGHT_BITS-1:0]   weight,
    input  logic [IN_FRACTION_BITS-1:0] random_fraction,
    output logic                        done,
    output logic [ID_BITS-1:0]          chosen_id,
    output logic [PROB_BITS-1:0]        probability,
    output logic [TOTAL_OUT_BITS-1:0]   weight_total,
    output logic [1:0]                  status
);

    localparam int IDX_W   = $clog2(ITEMS);
    localparam int ADDR_W  = $clog2(ITEMS + 1);
    localparam int CNT_W   = $clog2(ITEMS + 1);
    // The sum of ITEMS weights stays below 2^(WEIGHT_BITS + IDX_W).
    localparam int TOT_W   = WEIGHT_BITS + IDX_W;
    localparam int ACC_W   = TOT_W + FRACTION_BITS;
    localparam int QUO_W   = FRACTION_BITS + 1;
    localparam int STEP_W  = $clog2(FRACTION_BITS + 1);
    localparam int ENTRY_W = WEIGHT_BITS + 1;
    localparam int WIN_W   = (WEIGHT_BITS < IN_WEIGHT_BITS) ? WEIGHT_BITS : IN_WEIGHT_BITS;
    localparam int FIN_W   = (FRACTION_BITS < IN_FRACTION_BITS) ?
                             FRACTION_BITS : IN_FRACTION_BITS;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_ADD_NEW,
        S_DIV,
        S_MUL,
        S_WALK
    } state_t;

    // Control and output registers.
    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           addr_reg, addr_next;
    logic [TOT_W-1:0]            total_reg, total_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        rd_live_reg, rd_live_next;
    logic                        done_reg, done_next;
    logic [ID_BITS-1:0]          chosen_reg, chosen_next;
    logic [PROB_BITS-1:0]        prob_reg, prob_next;
    logic [TOTAL_OUT_BITS-1:0]   wtot_reg, wtot_next;
    status_t                     status_reg, status_next;

    // Datapath registers.
    kind_t                       kind_reg, kind_next;
    logic [ID_BITS-1:0]          id_reg, id_next;
    logic                        in_range_reg, in_range_next;
    logic [WEIGHT_BITS-1:0]      win_reg, win_next;
    logic [FRACTION_BITS-1:0]    frac_reg, frac_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [QUO_W-1:0]            quot_reg, quot_next;
    logic [TOT_W-1:0]            cum_reg, cum_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]            last_idx_reg, last_idx_next;

    // Shared adder/subtractor.
    logic [ACC_W-1:0]            alu_a;
    logic [ACC_W-1:0]            alu_b;
    logic                        alu_sub;
    logic [ACC_W:0]              alu_sum;
    logic [ACC_W-1:0]            alu_res;
    logic                        alu_carry;

    // Weight RAM: valid bit on top of the weight.
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [ENTRY_W-1:0]          ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [ENTRY_W-1:0]          rd_entry;
    logic                        rd_valid;
    logic [WEIGHT_BITS-1:0]      rd_weight;

    logic [IDX_W-1:0]            id_idx;
    logic                        present;
    logic [TOT_W-1:0]            walk_sum;

    wrdt_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (ITEMS)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign rd_valid  = rd_entry[WEIGHT_BITS];
    assign rd_weight = rd_entry[WEIGHT_BITS-1:0];
    assign id_idx    = IDX_W'(id_reg);
    assign present   = in_range_reg && rd_valid;

    // With alu_sub set this computes a - b, and the carry means a >= b.
    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {ACC_W{alu_sub}}}
                     + {{ACC_W{1'b0}}, alu_sub};
    assign alu_res   = alu_sum[ACC_W-1:0];
    assign alu_carry = alu_sum[ACC_W];
    assign walk_sum  = TOT_W'(alu_res);

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        total_next    = total_reg;
        count_next    = count_reg;
        rd_live_next  = rd_live_reg;
        done_next     = 1'b0;
        chosen_next   = id_reg;
        prob_next     = '0;
        status_next   = STATUS_OK;
        kind_next     = kind_reg;
        id_next       = id_reg;
        in_range_next = in_range_reg;
        win_next      = win_reg;
        frac_next     = frac_reg;
        acc_next      = acc_reg;
        quot_next     = quot_reg;
        cum_next      = cum_reg;
        step_next     = step_reg;
        rd_idx_next   = rd_idx_reg;
        last_idx_next = last_idx_reg;
        alu_a         = '0;
        alu_b         = '0;
        alu_sub       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = id_idx;
        ram_wdata     = '0;
        ram_raddr     = id_idx;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg[IDX_W-1:0];
                if (addr_reg == ADDR_W'(ITEMS - 1))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                // Read the addressed entry right away so it is ready in S_DECIDE.
                ram_raddr = IDX_W'(item_id);
                if (start)
                begin
                    kind_next     = kind_t'(kind);
                    id_next       = item_id;
                    in_range_next = int'(item_id) < ITEMS;
                    win_next      = WEIGHT_BITS'(weight[WIN_W-1:0]);
                    frac_next     = FRACTION_BITS'(random_fraction[FIN_W-1:0]);
                    state_next    = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                unique case (kind_reg)
                    KIND_SET:
                    begin
                        if (!in_range_reg)
                        begin
                            status_next = STATUS_UNKNOWN_ID;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {1'b1, win_reg};
                            state_next = S_ADD_NEW;
                            if (rd_valid)
                            begin
                                // Overwrite: take the old weight out first.
                                alu_a      = ACC_W'(total_reg);
                                alu_b      = ACC_W'(rd_weight);
                                alu_sub    = 1'b1;
                                total_next = TOT_W'(alu_res);
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end

                    KIND_REMOVE:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (!present)
                        begin
                            status_next = STATUS_UNKNOWN_ID;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = '0;
                            alu_a      = ACC_W'(total_reg);
                            alu_b      = ACC_W'(rd_weight);
                            alu_sub    = 1'b1;
                            total_next = TOT_W'(alu_res);
                            count_next = count_reg - 1'b1;
                        end
                    end

                    KIND_QUERY:
                    begin
                        if (!present)
                        begin
                            status_next = STATUS_UNKNOWN_ID;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (total_reg == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            acc_next   = ACC_W'(rd_weight);
                            quot_next  = '0;
                            step_next  = '0;
                            state_next = S_DIV;
                        end
                    end

                    KIND_DRAW:
                    begin
                        chosen_next = '0;
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (total_reg == '0)
                        begin
                            status_next = STATUS_ZERO_TOTAL;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            acc_next   = '0;
                            step_next  = '0;
                            state_next = S_MUL;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_ADD_NEW:
            begin
                alu_a      = ACC_W'(total_reg);
                alu_b      = ACC_W'(win_reg);
                total_next = TOT_W'(alu_res);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_DIV:
            begin
                // Restoring division; the first step takes the integer part,
                // which is one only when the weight equals the total.
                alu_a     = (step_reg == '0) ? acc_reg : (acc_reg << 1);
                alu_b     = ACC_W'(total_reg);
                alu_sub   = 1'b1;
                acc_next  = alu_carry ? alu_res : alu_a;
                quot_next = {quot_reg[QUO_W-2:0], alu_carry};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRACTION_BITS))
                begin
                    prob_next  = PROB_BITS'(quot_next);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_MUL:
            begin
                // Shift-add multiply of the total by the fraction, MSB first.
                alu_a     = acc_reg << 1;
                alu_b     = frac_reg[FRACTION_BITS-1] ? ACC_W'(total_reg) : '0;
                acc_next  = alu_res;
                frac_next = frac_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRACTION_BITS - 1))
                begin
                    addr_next    = '0;
                    rd_live_next = 1'b0;
                    cum_next     = '0;
                    state_next   = S_WALK;
                end
            end

            S_WALK:
            begin
                chosen_next = '0;
                ram_raddr   = addr_reg[IDX_W-1:0];
                if (addr_reg != ADDR_W'(ITEMS))
                begin
                    addr_next    = addr_reg + 1'b1;
                    rd_live_next = 1'b1;
                    rd_idx_next  = addr_reg[IDX_W-1:0];
                end
                else
                begin
                    rd_live_next = 1'b0;
                end

                alu_a = ACC_W'(cum_reg);
                alu_b = ACC_W'(rd_weight);
                if (rd_live_reg && rd_valid)
                begin
                    cum_next      = walk_sum;
                    last_idx_next = rd_idx_reg;
                    if (acc_reg <= {walk_sum, {FRACTION_BITS{1'b0}}})
                    begin
                        chosen_next = ID_BITS'(rd_idx_reg);
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (!rd_live_reg && (addr_reg == ADDR_W'(ITEMS)))
                begin
                    // Walk ran out without a match: report the last valid entry.
                    chosen_next = ID_BITS'(last_idx_reg);
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        wtot_next = TOTAL_OUT_BITS'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            rd_live_reg <= 1'b0;
            done_reg    <= 1'b0;
            chosen_reg  <= '0;
            prob_reg    <= '0;
            wtot_reg    <= '0;
            status_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            rd_live_reg <= rd_live_next;
            done_reg    <= done_next;
            chosen_reg  <= chosen_next;
            prob_reg    <= prob_next;
            wtot_reg    <= wtot_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        in_range_reg <= in_range_next;
        win_reg      <= win_next;
        frac_reg     <= frac_next;
        acc_reg      <= acc_next;
        quot_reg     <= quot_next;
        cum_reg      <= cum_next;
        step_reg     <= step_next;
        rd_idx_reg   <= rd_idx_next;
        last_idx_reg <= last_idx_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign chosen_id    = chosen_reg;
    assign probability  = prob_reg;
    assign weight_total = wtot_reg;
    assign status       = status_reg;

endmodule

[rtl/wrdt_checker.sv]
// Port-level assertions for the weighted random draw table, with the bind that
// attaches them to the top level. Depends on wrdt_pkg.
module wrdt_checker
    import wrdt_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [ID_BITS-1:0]        chosen_id,
    input logic [PROB_BITS-1:0]      probability,
    input logic [TOTAL_OUT_BITS-1:0] weight_total,
    input logic [1:0]                status
);

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result is a single-cycle strobe.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // A result always closes a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result without a preceding busy period");

    // An empty table has no weight and draws nothing.
    a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_EMPTY)) |->
        ((weight_total == '0) && (chosen_id == '0) && (probability == '0)))
        else $error("empty-table result with nonzero fields");

    // Only a successful operation can report a probability.
    a_prob_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (probability == '0))
        else $error("probability reported with an error status");

endmodule

bind weighted_random_draw_table wrdt_checker u_wrdt_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .chosen_id    (chosen_id),
    .probability  (probability),
    .weight_total (weight_total),
    .status       (status)
);
